### hw/rtl/indexed_min_heap_defines.svh
// Assertion macros shared by the indexed min-heap RTL.
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define IMH_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define IMH_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/imh_pkg.sv
// Types and constants of the indexed min-heap.
`timescale 1ns / 1ps
package imh_pkg;
  localparam int unsigned HEAP_DEPTH  = 1024;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned HND_W       = 16;
  localparam int unsigned STAT_W      = 2;

  localparam logic CMD_UPSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic             command;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic              update_valid;
    logic [HND_W-1:0]  moved_handle;
    logic [POS_W-1:0]  moved_position;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entry_total;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [POS_W-1:0] rd_addr_a;
    logic [POS_W-1:0] rd_addr_b;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [HND_W-1:0] wr_handle;
  } mem_req_t;
endpackage

### hw/rtl/imh_store.sv
// Heap entry memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module imh_store import imh_pkg::*; #(
  parameter int unsigned HANDLE_BITS = imh_pkg::HANDLE_BITS
) (
  input  logic             clk,
  input  mem_req_t         req,
  output logic [KEY_W-1:0] rd_key_a,
  output logic [HND_W-1:0] rd_hnd_a,
  output logic [KEY_W-1:0] rd_key_b,
  output logic [HND_W-1:0] rd_hnd_b
);
  localparam int unsigned SW = (HANDLE_BITS < HND_W) ? HANDLE_BITS : HND_W;

  logic [KEY_W-1:0] key_mem [HEAP_DEPTH];
  logic [SW-1:0]    hnd_mem [HEAP_DEPTH];
  logic [SW-1:0]    hnd_a;
  logic [SW-1:0]    hnd_b;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_key;
      hnd_mem[req.wr_addr] <= req.wr_handle[SW-1:0];
    end
    rd_key_a <= key_mem[req.rd_addr_a];
    hnd_a    <= hnd_mem[req.rd_addr_a];
    rd_key_b <= key_mem[req.rd_addr_b];
    hnd_b    <= hnd_mem[req.rd_addr_b];
  end

  assign rd_hnd_a = HND_W'(hnd_a);
  assign rd_hnd_b = HND_W'(hnd_b);
endmodule

### hw/rtl/indexed_min_heap.sv
// Indexed binary min-heap: command sequencer around the entry memory.
//   channel | handshake           | payload
//   command | cmd_valid/cmd_ready | cmd (cmd_t)
//   result  | res_valid/res_ready | res (res_t)
// A status-only command goes straight to the result without reading the entry memory. Any other
// command walks the heap one level at a time (memory read, then compare and write back),
// ends with the final placement, and on a delete first fetches the tail entry.
// Each result waits while res_valid is high and res_ready low, which adds stall cycles.
// Commands are taken only while the sequencer is idle; a result in the output
// register does not block the next command. Reset clears state, entry count and
// res_valid; the entry memory is not cleared.
`timescale 1ns / 1ps
`include "indexed_min_heap_defines.svh"
module indexed_min_heap import imh_pkg::*; #(
  parameter int unsigned HANDLE_BITS = imh_pkg::HANDLE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  localparam int unsigned SW = (HANDLE_BITS < HND_W) ? HANDLE_BITS : HND_W;
  localparam logic [HND_W-1:0] HMASK = HND_W'((64'd1 << SW) - 64'd1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_TAIL     = 8'b00000010,
    S_UP       = 8'b00000100,
    S_UP_CMP   = 8'b00001000,
    S_DOWN     = 8'b00010000,
    S_DOWN_CMP = 8'b00100000,
    S_FINAL    = 8'b01000000,
    S_NOTE     = 8'b10000000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [KEY_W-1:0]  cur_key, key_next;
  logic [HND_W-1:0]  cur_hnd, hnd_next;
  logic              moved_up, up_next;
  logic [STAT_W-1:0] note, note_next;

  mem_req_t          req;
  logic [KEY_W-1:0]  rd_key_a, rd_key_b;
  logic [HND_W-1:0]  rd_hnd_a, rd_hnd_b;

  logic              can_emit;
  logic              emit;
  res_t              emit_d;
  logic [POS_W-1:0]  par;
  logic [CNT_W:0]    lft, rgt;
  logic              l_ok, r_ok;
  logic [CNT_W-1:0]  tail;
  logic              pick_l, pick_r;
  logic [KEY_W-1:0]  lk_min;

  imh_store #(.HANDLE_BITS(HANDLE_BITS)) u_store (
    .clk      (clk),
    .req      (req),
    .rd_key_a (rd_key_a),
    .rd_hnd_a (rd_hnd_a),
    .rd_key_b (rd_key_b),
    .rd_hnd_b (rd_hnd_b)
  );

  assign can_emit  = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE);
  assign par  = POS_W'((pos - POS_W'(1)) >> 1);
  assign lft  = {1'b0, pos, 1'b1};
  assign rgt  = lft + (CNT_W+1)'(1);
  assign l_ok = lft < {1'b0, count};
  assign r_ok = rgt < {1'b0, count};
  assign tail = count - CNT_W'(1);

  // smaller child, left wins ties
  assign pick_l = l_ok && (rd_key_a < cur_key);
  assign lk_min = pick_l ? rd_key_a : cur_key;
  assign pick_r = r_ok && (rd_key_b < lk_min);

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    key_next   = cur_key;
    hnd_next   = cur_hnd;
    up_next    = moved_up;
    note_next  = note;
    req           = '0;
    req.rd_addr_a = par;
    req.rd_addr_b = rgt[POS_W-1:0];
    emit   = 1'b0;
    emit_d = '0;
    emit_d.entry_total = count;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          up_next  = 1'b0;
          key_next = cmd.key;
          hnd_next = cmd.handle & HMASK;
          pos_next = cmd.position;
          if (cmd.command == CMD_UPSERT) begin
            if ({1'b0, cmd.position} >= count) begin
              if (count >= CNT_W'(HEAP_DEPTH)) begin
                note_next  = STAT_FULL;
                state_next = S_NOTE;
              end else begin
                pos_next   = count[POS_W-1:0];
                count_next = count + CNT_W'(1);
                state_next = S_UP;
              end
            end else begin
              state_next = S_UP;
            end
          end else begin
            if ({1'b0, cmd.position} >= count) begin
              note_next  = STAT_RANGE;
              state_next = S_NOTE;
            end else if ({1'b0, cmd.position} == tail) begin
              count_next = tail;
              note_next  = STAT_OK;
              state_next = S_NOTE;
            end else begin
              count_next    = tail;
              req.rd_addr_a = tail[POS_W-1:0];
              state_next    = S_TAIL;
            end
          end
        end
      end
      S_TAIL: begin
        key_next   = rd_key_a;
        hnd_next   = rd_hnd_a;
        state_next = S_UP;
      end
      S_UP: begin
        if (pos == '0) begin
          state_next = moved_up ? S_FINAL : S_DOWN;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (rd_key_a > cur_key) begin
          if (can_emit) begin
            req.wr_en     = 1'b1;
            req.wr_addr   = pos;
            req.wr_key    = rd_key_a;
            req.wr_handle = rd_hnd_a;
            emit                  = 1'b1;
            emit_d.update_valid   = 1'b1;
            emit_d.moved_handle   = rd_hnd_a;
            emit_d.moved_position = pos;
            pos_next   = par;
            up_next    = 1'b1;
            state_next = S_UP;
          end
        end else begin
          state_next = moved_up ? S_FINAL : S_DOWN;
        end
      end
      S_DOWN: begin
        req.rd_addr_a = lft[POS_W-1:0];
        state_next    = l_ok ? S_DOWN_CMP : S_FINAL;
      end
      S_DOWN_CMP: begin
        req.rd_addr_a = lft[POS_W-1:0];
        if (!pick_l && !pick_r) begin
          state_next = S_FINAL;
        end else if (can_emit) begin
          req.wr_en     = 1'b1;
          req.wr_addr   = pos;
          req.wr_key    = pick_r ? rd_key_b : rd_key_a;
          req.wr_handle = pick_r ? rd_hnd_b : rd_hnd_a;
          emit                  = 1'b1;
          emit_d.update_valid   = 1'b1;
          emit_d.moved_handle   = req.wr_handle;
          emit_d.moved_position = pos;
          pos_next   = pick_r ? rgt[POS_W-1:0] : lft[POS_W-1:0];
          state_next = S_DOWN;
        end
      end
      S_FINAL: begin
        if (can_emit) begin
          req.wr_en     = 1'b1;
          req.wr_addr   = pos;
          req.wr_key    = cur_key;
          req.wr_handle = cur_hnd;
          emit                  = 1'b1;
          emit_d.update_valid   = 1'b1;
          emit_d.moved_handle   = cur_hnd;
          emit_d.moved_position = pos;
          emit_d.last           = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NOTE: begin
        if (can_emit) begin
          emit          = 1'b1;
          emit_d.status = note;
          emit_d.last   = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur_key  <= key_next;
    cur_hnd  <= hnd_next;
    moved_up <= up_next;
    note     <= note_next;
    if (emit) begin
      res <= emit_d;
    end
  end

  `IMH_ALWAYS(a_count_bound, count <= CNT_W'(HEAP_DEPTH), "entry count beyond heap depth")
  `IMH_IMPLY(a_write_reported, req.wr_en, emit, "slot write without a reported placement")
  `IMH_IMPLY(a_write_in_heap, req.wr_en, ({1'b0, req.wr_addr} < count), "slot write beyond size")
  `IMH_IMPLY(a_bare_is_last, res_valid && !res.update_valid, res.last, "non-placement result not last")
endmodule
